FILE: rtl/pmse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmse_pkg
// Shared widths, register codes, fix-up state type and saturating helpers
// for the periodic maintenance schedule evaluator.
// ----------------------------------------------------------------------------
package pmse_pkg;

	localparam int TIME_W = 32;
	localparam int INC_W  = TIME_W + 1;
	localparam int LAT_W  = (TIME_W > 32) ? TIME_W : 32;
	localparam int PROD_W = INC_W + 16;
	localparam int CNT_W  = $clog2(TIME_W);

	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic [31:0]       OUT_MAX  = 32'hFFFF_FFFF;

	localparam logic [15:0] PERIOD_RST = 16'd100;
	localparam logic [15:0] MAINT_RST  = 16'd0;

	localparam logic CFG_PERIOD = 1'b0;
	localparam logic CFG_MAINT  = 1'b1;

	typedef enum logic [1:0] {
		FX_IDLE,
		FX_DIV,
		FX_MUL,
		FX_READY
	} fx_state_t;

	typedef struct packed {
		logic              ready;
		logic [TIME_W-1:0] inc_b;
		logic [TIME_W-1:0] inc_t;
	} pmse_fx_t;

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
			input logic [INC_W-1:0] b);
		logic [INC_W:0] s;
		s = {2'b00, a} + {1'b0, b};
		return (s > (INC_W + 1)'(TIME_MAX)) ? TIME_MAX : s[TIME_W-1:0];
	endfunction

	// task would cross the boundary badly: wait for the next period
	function automatic logic must_defer(input logic [TIME_W-1:0] t,
			input logic [TIME_W-1:0] b, input logic [15:0] len,
			input logic [15:0] tv, input logic [15:0] p);
		logic [TIME_W-1:0] fin;
		logic [TIME_W-1:0] nxt;
		logic [TIME_W-1:0] fin_m;
		fin   = sat_add(t, INC_W'(len));
		nxt   = sat_add(b, INC_W'(tv));
		fin_m = sat_add(fin, INC_W'(p));
		return (fin >= nxt) || ((fin >= b) && (fin_m > nxt));
	endfunction

	function automatic logic [31:0] out_sat(input logic [TIME_W-1:0] v);
		logic [LAT_W-1:0] w;
		w = LAT_W'(v);
		return (w > LAT_W'(OUT_MAX)) ? OUT_MAX : w[31:0];
	endfunction

endpackage

FILE: rtl/pmse_fixup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmse_fixup
// Multi-cycle catch-up unit: divides the overrun past the boundary by the
// usable period length, then forms the saturated boundary and time steps.
// ----------------------------------------------------------------------------
module pmse_fixup
	import pmse_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              need,
	input  logic              flush,
	input  logic [TIME_W-1:0] dividend,
	input  logic [15:0]       divisor,
	input  logic [15:0]       tv,
	input  logic [15:0]       p,
	output pmse_fx_t          fx
);

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIME_W - 1);

	fx_state_t st_q;
	fx_state_t st_nxt;

	logic              load;
	logic              step;
	logic              mul;
	logic              fx_ready;
	logic [CNT_W-1:0]  cnt_q;
	logic [15:0]       rem_q;
	logic [TIME_W-1:0] quo_q;
	logic [15:0]       dvs_q;
	logic [15:0]       tv_q;
	logic [15:0]       p_q;
	logic [TIME_W-1:0] inc_b_q;
	logic [TIME_W-1:0] inc_t_q;

	logic [16:0]       trial;
	logic              trial_ge;
	logic [16:0]       trial_sub;
	logic [INC_W-1:0]  n_slots;
	logic [PROD_W-1:0] prod_b;
	logic [PROD_W-1:0] prod_t;

	always_comb begin
		st_nxt = st_q;
		case (st_q)
			FX_IDLE: begin
				if (need)
					st_nxt = FX_DIV;
			end
			FX_DIV: begin
				if (cnt_q == CNT_LAST)
					st_nxt = FX_MUL;
			end
			FX_MUL: begin
				st_nxt = FX_READY;
			end
			FX_READY: begin
				st_nxt = FX_READY;
			end
			default: begin
				st_nxt = FX_IDLE;
			end
		endcase
		if (flush)
			st_nxt = FX_IDLE;
	end

	always_comb begin
		load     = 1'b0;
		step     = 1'b0;
		mul      = 1'b0;
		fx_ready = 1'b0;
		case (st_q)
			FX_IDLE:  load     = need && !flush;
			FX_DIV:   step     = 1'b1;
			FX_MUL:   mul      = 1'b1;
			FX_READY: fx_ready = 1'b1;
			default:  load     = 1'b0;
		endcase
	end

	assign fx = '{ready: fx_ready, inc_b: inc_b_q, inc_t: inc_t_q};

	// restoring division, one quotient bit per cycle
	assign trial     = {rem_q, quo_q[TIME_W-1]};
	assign trial_ge  = trial >= {1'b0, dvs_q};
	assign trial_sub = trial - {1'b0, dvs_q};

	assign n_slots = INC_W'(quo_q) + INC_W'(1);
	assign prod_b  = PROD_W'(n_slots) * PROD_W'(tv_q);
	assign prod_t  = PROD_W'(n_slots) * PROD_W'(p_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= FX_IDLE;
		else
			st_q <= st_nxt;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cnt_q <= '0;
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
			tv_q  <= tv;
			p_q   <= p;
		end else if (step) begin
			cnt_q <= cnt_q + CNT_W'(1);
			rem_q <= trial_ge ? trial_sub[15:0] : trial[15:0];
			quo_q <= {quo_q[TIME_W-2:0], trial_ge};
		end
		if (mul) begin
			inc_b_q <= (prod_b > PROD_W'(TIME_MAX)) ? TIME_MAX : prod_b[TIME_W-1:0];
			inc_t_q <= (prod_t > PROD_W'(TIME_MAX)) ? TIME_MAX : prod_t[TIME_W-1:0];
		end
	end

endmodule

FILE: rtl/periodic_maintenance_schedule_eval_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_maintenance_schedule_eval_top
// Evaluates one task order on a machine with a maintenance slot at the
// start of every period; gives makespan and total tardiness per order.
// ----------------------------------------------------------------------------
// One task beat is taken per cycle while in_stall is low, and a result beat (on
// the last task of an order, or on a task that can never fit) passes through the
// stage 1 register and then the result register. The schedule state is updated by
// a single pass of adds and compares, so back-to-back tasks flow without bubbles.
// The input stalls when a result beat is held back by out_stall, and also when the
// period or maintenance length is rewritten in the middle of an order, leaving the
// machine two or more usable periods (period minus maintenance) past its boundary;
// it then waits for the 32-bit restoring divider and a multiply step before the
// next task is taken. There is no clearing pass after reset.

module periodic_maintenance_schedule_eval_top
	import pmse_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] task_length,
	input  logic [31:0] task_deadline,
	input  logic        last_task,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] makespan,
	output logic [31:0] total_tardiness,
	output logic        unschedulable
);

	logic [15:0]       period_q;
	logic [15:0]       maint_q;
	logic [TIME_W-1:0] time_q;
	logic [TIME_W-1:0] bnd_q;
	logic              skip_q;
	logic [TIME_W-1:0] sum_q;

	logic              valid_s1;
	logic              fail_s1;
	logic              last_s1;
	logic [TIME_W-1:0] time_s1;
	logic [31:0]       dl_s1;

	logic              out_valid_q;
	logic [31:0]       makespan_q;
	logic [31:0]       tard_q;
	logic              unsch_q;

	logic [15:0]       tv;
	logic              pt_bad;
	logic [15:0]       tp;
	logic              ge;
	logic [TIME_W-1:0] diff;
	logic              q_one;
	logic              need_fx;
	logic [INC_W-1:0]  inc_b;
	logic [INC_W-1:0]  inc_t;
	logic [TIME_W-1:0] b1;
	logic [TIME_W-1:0] t1;
	logic              ok1;
	logic              def1;
	logic [TIME_W-1:0] b2;
	logic [TIME_W-1:0] t2;
	logic              ok2;
	logic              ok;
	logic [TIME_W-1:0] t_sel;
	logic [TIME_W-1:0] b_sel;
	logic [TIME_W-1:0] t_end;

	logic              fx_wait;
	logic              flush;
	logic              in_acc;
	logic              emit_s1;
	logic              out_free;
	logic              adv_s1;
	pmse_fx_t          fx;

	logic              late;
	logic [LAT_W-1:0]  lat_full;
	logic [TIME_W-1:0] sum_new;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
			maint_q  <= MAINT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_PERIOD: period_q <= cfg_data;
				CFG_MAINT:  maint_q  <= cfg_data;
				default:    period_q <= period_q;
			endcase
		end
	end

	// pending maintenance and fit test
	assign tv     = (period_q == 16'd0) ? 16'd1 : period_q;
	assign pt_bad = maint_q >= tv;
	assign tp     = tv - maint_q;
	assign ge     = time_q >= bnd_q;
	assign diff   = time_q - bnd_q;
	assign q_one  = INC_W'(diff) >= INC_W'(tp);

	// more than one slot behind only happens after a mid-order rewrite
	assign need_fx = !skip_q && ge && !pt_bad && (INC_W'(diff) >= INC_W'({tp, 1'b0}));

	always_comb begin
		if (need_fx) begin
			inc_b = INC_W'(fx.inc_b);
			inc_t = INC_W'(fx.inc_t);
		end else if (q_one) begin
			inc_b = INC_W'({tv, 1'b0});
			inc_t = INC_W'({maint_q, 1'b0});
		end else begin
			inc_b = INC_W'(tv);
			inc_t = INC_W'(maint_q);
		end
	end

	assign b1   = ge ? sat_add(bnd_q, inc_b) : bnd_q;
	assign t1   = ge ? sat_add(time_q, inc_t) : time_q;
	assign ok1  = !ge || (!pt_bad && (t1 < b1));
	assign def1 = must_defer(t1, b1, task_length, tv, maint_q);

	// deferred: jump to the boundary, take exactly one maintenance slot
	assign b2  = sat_add(b1, INC_W'(tv));
	assign t2  = sat_add(b1, INC_W'(maint_q));
	assign ok2 = !pt_bad && (t2 < b2) && !must_defer(t2, b2, task_length, tv, maint_q);
	assign ok  = ok1 && (!def1 || ok2);

	assign t_sel = def1 ? t2 : t1;
	assign b_sel = def1 ? b2 : b1;
	assign t_end = sat_add(t_sel, INC_W'(task_length));

	// handshake
	assign emit_s1  = fail_s1 || last_s1;
	assign out_free = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && (!emit_s1 || out_free);
	assign fx_wait  = need_fx && !fx.ready;
	assign in_stall = (valid_s1 && !adv_s1) || fx_wait;
	assign in_acc   = in_valid && !in_stall;
	assign flush    = cfg_write || in_acc;

	pmse_fixup u_fixup (
		.clk      (clk),
		.arst_n   (arst_n),
		.need     (need_fx),
		.flush    (flush),
		.dividend (diff),
		.divisor  (tp),
		.tv       (tv),
		.p        (maint_q),
		.fx       (fx)
	);

	// run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
			bnd_q  <= '0;
			skip_q <= 1'b0;
		end else if (in_acc) begin
			if (skip_q) begin
				skip_q <= !last_task;
			end else if (!ok) begin
				time_q <= '0;
				bnd_q  <= '0;
				skip_q <= !last_task;
			end else if (last_task) begin
				time_q <= '0;
				bnd_q  <= '0;
			end else begin
				time_q <= t_end;
				bnd_q  <= b_sel;
			end
		end
	end

	// stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_acc && !skip_q)
			valid_s1 <= 1'b1;
		else if (adv_s1)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_acc && !skip_q) begin
			fail_s1 <= !ok;
			last_s1 <= last_task;
			time_s1 <= t_end;
			dl_s1   <= task_deadline;
		end
	end

	// tardiness
	assign late     = LAT_W'(time_s1) > LAT_W'(dl_s1);
	assign lat_full = LAT_W'(time_s1) - LAT_W'(dl_s1);
	assign sum_new  = late ? sat_add(sum_q, INC_W'(lat_full[TIME_W-1:0])) : sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sum_q <= '0;
		else if (adv_s1)
			sum_q <= emit_s1 ? '0 : sum_new;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv_s1 && emit_s1)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit_s1) begin
			makespan_q <= fail_s1 ? 32'd0 : out_sat(time_s1);
			tard_q     <= fail_s1 ? 32'd0 : out_sat(sum_new);
			unsch_q    <= fail_s1;
		end
	end

	assign out_valid       = out_valid_q;
	assign makespan        = makespan_q;
	assign total_tardiness = tard_q;
	assign unschedulable   = unsch_q;

endmodule

FILE: rtl/pmse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmse_checker
// Port-level checks on the result channel of the schedule evaluator,
// bound to the top level.
// ----------------------------------------------------------------------------
module pmse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] makespan,
	input logic [31:0] total_tardiness,
	input logic        unschedulable
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(makespan)
			&& $stable(total_tardiness) && $stable(unschedulable))
		else $error("result beat changed while stalled");

	// an aborted order reports zero makespan and tardiness
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unschedulable |-> makespan == 32'd0 && total_tardiness == 32'd0)
		else $error("unschedulable result with nonzero sums");

	// a fresh result comes from an earlier accepted task beat
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result beat without a matching task beat");

endmodule

bind periodic_maintenance_schedule_eval_top pmse_checker u_pmse_checker (.*);
